// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the countdown timer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/cth_pkg.sv =====
// ----------------------------------------------------------------------------
// cth_pkg
// types, codes and constants of the countdown timer
// ----------------------------------------------------------------------------
package cth_pkg;

	localparam int REQ_W       = 3;
	localparam int SEL_W       = 2;
	localparam int VALUE_W     = 13;
	localparam int TOTAL_W     = 18;
	localparam int HMS_W       = 6;
	localparam int MIN_TOTAL_W = 12;

	// request codes; the unused code acts as status only
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESET  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_STATUS = 3'd6;

	// field selector codes; the fourth code is ignored
	localparam logic [SEL_W-1:0] SEL_HOURS   = 2'd0;
	localparam logic [SEL_W-1:0] SEL_MINUTES = 2'd1;
	localparam logic [SEL_W-1:0] SEL_SECONDS = 2'd2;

	localparam int FIELD_MODULUS = 60;
	localparam int SECS_PER_MIN  = 60;
	localparam int SECS_PER_HOUR = 3600;

	localparam logic [TOTAL_W-1:0] ELAPSED_MAX = '1;

	// multiple of the modulus that lifts any field sum above zero
	localparam int WRAP_W      = 15;
	localparam int WRAP_OFFSET = (8192 / FIELD_MODULUS + 1) * FIELD_MODULUS;

	// reciprocal constants, exact for every value below 2**18
	localparam int RECIP_W    = 19;
	localparam int PROD_W     = TOTAL_W + RECIP_W;
	localparam int HOUR_RECIP = 298262;
	localparam int HOUR_SHIFT = 30;
	localparam int MIN_RECIP  = 279621;
	localparam int MIN_SHIFT  = 24;

	typedef struct packed {
		logic [HMS_W-1:0]   hours;
		logic [HMS_W-1:0]   minutes;
		logic [HMS_W-1:0]   seconds;
		logic               running;
		logic [TOTAL_W-1:0] elapsed;
	} timer_state_t;

	// x mod 60 by folding: 64 is 4 mod 60, so each fold maps hi*64+lo to hi*4+lo
	function automatic logic [HMS_W-1:0] mod_sixty(input logic [TOTAL_W-1:0] x);
		logic [14:0] a;
		logic [10:0] b;
		logic [6:0]  c;
		a = {1'b0, x[17:6], 2'b00} + 15'(x[5:0]);
		b = {a[14:6], 2'b00} + 11'(a[5:0]);
		c = {b[10:6], 2'b00} + 7'(b[5:0]);
		if (c >= 7'(2 * FIELD_MODULUS)) begin
			c = c - 7'(2 * FIELD_MODULUS);
		end else if (c >= 7'(FIELD_MODULUS)) begin
			c = c - 7'(FIELD_MODULUS);
		end
		return c[HMS_W-1:0];
	endfunction

endpackage

// ===== hdl/cth_req_if.sv =====
// ----------------------------------------------------------------------------
// cth_req_if
// request channel of the countdown timer
// ----------------------------------------------------------------------------
interface cth_req_if;
	import cth_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic [SEL_W-1:0]          field_select;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output req_type, output field_select, output value,
		input ready);
	modport sink (input valid, input req_type, input field_select, input value,
		output ready);
endinterface

// ===== hdl/cth_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cth_rsp_if
// result channel of the countdown timer
// ----------------------------------------------------------------------------
interface cth_rsp_if;
	import cth_pkg::*;

	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] remaining_total;
	logic [HMS_W-1:0]   remaining_hours;
	logic [HMS_W-1:0]   remaining_minutes;
	logic [HMS_W-1:0]   remaining_secs;
	logic               is_running;
	logic               is_paused;
	logic               is_expired;

	modport source (output valid, output remaining_total, output remaining_hours,
		output remaining_minutes, output remaining_secs, output is_running,
		output is_paused, output is_expired, input ready);
	modport sink (input valid, input remaining_total, input remaining_hours,
		input remaining_minutes, input remaining_secs, input is_running,
		input is_paused, input is_expired, output ready);
endinterface

// ===== hdl/cth_state.sv =====
// ----------------------------------------------------------------------------
// cth_state
// timer state registers and the per-request update
// ----------------------------------------------------------------------------
module cth_state (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic [cth_pkg::REQ_W-1:0]          req_type,
	input  logic [cth_pkg::SEL_W-1:0]          field_select,
	input  logic signed [cth_pkg::VALUE_W-1:0] value,
	output cth_pkg::timer_state_t              st
);
	import cth_pkg::*;

	timer_state_t       st_q;
	timer_state_t       st_nxt;
	logic [HMS_W-1:0]   cur_field;
	logic [HMS_W-1:0]   base;
	logic [WRAP_W-1:0]  wrap_sum;
	logic [HMS_W-1:0]   wrapped;

	always_comb begin
		case (field_select)
			SEL_HOURS:   cur_field = st_q.hours;
			SEL_MINUTES: cur_field = st_q.minutes;
			SEL_SECONDS: cur_field = st_q.seconds;
			default:     cur_field = '0;
		endcase
	end

	assign base     = (req_type == REQ_ADD) ? cur_field : '0;
	// offset keeps the sum positive so the fold sees an unsigned value
	assign wrap_sum = WRAP_W'(base) + {{(WRAP_W - VALUE_W){value[VALUE_W-1]}}, value}
		+ WRAP_W'(WRAP_OFFSET);
	assign wrapped  = mod_sixty(TOTAL_W'(wrap_sum));

	always_comb begin
		st_nxt = st_q;
		case (req_type)
			REQ_SET, REQ_ADD: begin
				case (field_select)
					SEL_HOURS:   st_nxt.hours   = wrapped;
					SEL_MINUTES: st_nxt.minutes = wrapped;
					SEL_SECONDS: st_nxt.seconds = wrapped;
					default:     ;
				endcase
			end
			REQ_START: st_nxt.running = 1'b1;
			REQ_PAUSE: st_nxt.running = 1'b0;
			REQ_RESET: begin
				st_nxt.running = 1'b0;
				st_nxt.elapsed = '0;
			end
			REQ_TICK: begin
				if (st_q.running && (st_q.elapsed != ELAPSED_MAX)) begin
					st_nxt.elapsed = st_q.elapsed + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (load) begin
			st_q <= st_nxt;
		end
	end

	assign st = st_q;
endmodule

// ===== hdl/countdown_timer_hms_pause_unit.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_hms_pause_unit
// countdown timer with h:m:s length, start, pause, reset and second ticks
// ----------------------------------------------------------------------------
// The timer takes one request per cycle and returns one result per request,
// in order. A request is applied to the timer state on the transfer edge;
// with the result side always ready the block sustains one transfer per
// clock on each side. After the request transfer its result passes through
// a stage that forms the set length and the clamped remaining time, a stage
// with the two reciprocal multipliers that give hours and total minutes, and
// the output register that forms the minutes. Backpressure stops only the
// stages behind a full one, so requests keep flowing into empty slots while
// a result waits to be taken. Every result reflects the state after its own
// request.
`include "assert_macros.svh"

module countdown_timer_hms_pause_unit (
	input  logic      clk,
	input  logic      arst_n,
	cth_req_if.sink   req,
	cth_rsp_if.source rsp
);
	import cth_pkg::*;

	typedef struct packed {
		logic running;
		logic paused;
		logic expired;
	} flags_t;

	// handshake chain: each stage moves when it is empty or the next one moves
	logic v_s0;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic adv1;
	logic adv2;
	logic adv3;
	logic req_xfer;

	timer_state_t st;

	// stage 1 logic and registers
	logic [TOTAL_W-1:0] length;
	logic               expired;
	logic [TOTAL_W-1:0] rem_s1;
	flags_t             flags_s1;

	// stage 2 logic and registers
	logic [PROD_W-1:0]      hour_prod;
	logic [PROD_W-1:0]      min_prod;
	logic [TOTAL_W-1:0]     rem_s2;
	logic [HMS_W-1:0]       hours_s2;
	logic [MIN_TOTAL_W-1:0] tot_min_s2;
	logic [HMS_W-1:0]       seconds_s2;
	flags_t                 flags_s2;

	// output register
	logic [MIN_TOTAL_W-1:0] min_diff;
	logic [TOTAL_W-1:0]     rem_s3;
	logic [HMS_W-1:0]       hours_s3;
	logic [HMS_W-1:0]       minutes_s3;
	logic [HMS_W-1:0]       seconds_s3;
	flags_t                 flags_s3;

	// result consistency terms for the checks
	logic               hms_in_range;
	logic [TOTAL_W-1:0] hms_total;

	assign adv3      = !v_s3 || rsp.ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = !v_s0 || adv1;
	assign req_xfer  = req.valid && req.ready;

	// the state registers double as stage 0: their contents are pending
	// until stage 1 has taken a snapshot
	cth_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (req_xfer),
		.req_type     (req.req_type),
		.field_select (req.field_select),
		.value        (req.value),
		.st           (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (req_xfer) begin
				v_s0 <= 1'b1;
			end else if (adv1) begin
				v_s0 <= 1'b0;
			end
			if (adv1) begin
				v_s1 <= v_s0;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: set length in seconds and the clamped remaining time
	assign length = TOTAL_W'(st.hours) * TOTAL_W'(SECS_PER_HOUR)
		+ TOTAL_W'(st.minutes) * TOTAL_W'(SECS_PER_MIN)
		+ TOTAL_W'(st.seconds);
	assign expired = (st.elapsed >= length);

	always_ff @(posedge clk) begin
		if (adv1) begin
			rem_s1           <= expired ? '0 : (length - st.elapsed);
			flags_s1.running <= st.running;
			flags_s1.paused  <= !st.running && (st.elapsed != '0);
			flags_s1.expired <= expired;
		end
	end

	// stage 2: hours and total minutes by reciprocal multiply, seconds by folding
	assign hour_prod = PROD_W'(rem_s1) * PROD_W'(HOUR_RECIP);
	assign min_prod  = PROD_W'(rem_s1) * PROD_W'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv2) begin
			rem_s2     <= rem_s1;
			hours_s2   <= hour_prod[HOUR_SHIFT +: HMS_W];
			tot_min_s2 <= min_prod[MIN_SHIFT +: MIN_TOTAL_W];
			seconds_s2 <= mod_sixty(rem_s1);
			flags_s2   <= flags_s1;
		end
	end

	// output register: minutes = total minutes - hours*60 (64h - 4h)
	assign min_diff = tot_min_s2
		- (MIN_TOTAL_W'({hours_s2, 6'b0}) - MIN_TOTAL_W'({hours_s2, 2'b0}));

	always_ff @(posedge clk) begin
		if (adv3) begin
			rem_s3     <= rem_s2;
			hours_s3   <= hours_s2;
			minutes_s3 <= min_diff[HMS_W-1:0];
			seconds_s3 <= seconds_s2;
			flags_s3   <= flags_s2;
		end
	end

	assign rsp.valid             = v_s3;
	assign rsp.remaining_total   = rem_s3;
	assign rsp.remaining_hours   = hours_s3;
	assign rsp.remaining_minutes = minutes_s3;
	assign rsp.remaining_secs    = seconds_s3;
	assign rsp.is_running        = flags_s3.running;
	assign rsp.is_paused         = flags_s3.paused;
	assign rsp.is_expired        = flags_s3.expired;

	assign hms_in_range = (rsp.remaining_hours < HMS_W'(FIELD_MODULUS))
		&& (rsp.remaining_minutes < HMS_W'(FIELD_MODULUS))
		&& (rsp.remaining_secs < HMS_W'(FIELD_MODULUS));
	assign hms_total = TOTAL_W'(rsp.remaining_hours) * TOTAL_W'(SECS_PER_HOUR)
		+ TOTAL_W'(rsp.remaining_minutes) * TOTAL_W'(SECS_PER_MIN)
		+ TOTAL_W'(rsp.remaining_secs);

	// checks on the result path and the state update
	`ASSERT_SAME(a_hms_range, clk, arst_n, rsp.valid, hms_in_range)
	`ASSERT_SAME(a_hms_sum, clk, arst_n, rsp.valid, hms_total == rsp.remaining_total)
	`ASSERT_SAME(a_expired_zero, clk, arst_n, rsp.valid, rsp.is_expired == (rsp.remaining_total == '0))
	`ASSERT_SAME(a_run_pause, clk, arst_n, rsp.valid, !(rsp.is_running && rsp.is_paused))
	`ASSERT_NEXT(a_start_runs, clk, arst_n, req_xfer && (req.req_type == REQ_START), st.running)
endmodule

// ===== tb/sv/tb_countdown_timer_hms_pause_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_countdown_timer_hms_pause_unit
// self-checking bench for the h:m:s countdown timer with pause
// ----------------------------------------------------------------------------
// Requests go in on the request channel in bursts with random gaps, while the
// result side stalls on a pattern of its own. A scoreboard keeps its own copy
// of the timer state, predicts the reading that each accepted request yields
// and checks every accepted result against the oldest prediction, field by
// field. The run has a short directed part and a random part made mostly of
// countdown sequences with random content.
module tb_countdown_timer_hms_pause_unit;
	import cth_pkg::*;

	// codes with no name in the package
	localparam logic [REQ_W-1:0] REQ_UNUSED  = 3'd7;
	localparam logic [SEL_W-1:0] SEL_INVALID = 2'd3;

	localparam int RANDOM_ITEMS = 1850;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [SEL_W-1:0]   sel;
		logic [VALUE_W-1:0] amount;
	} timer_request_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [HMS_W-1:0]   hours;
		logic [HMS_W-1:0]   minutes;
		logic [HMS_W-1:0]   seconds;
		logic               running;
		logic               paused;
		logic               expired;
	} timer_reading_t;

	// shadow timer plus the readings that are still owed by the block
	class countdown_scoreboard;
		bit [HMS_W-1:0]   len_hours;
		bit [HMS_W-1:0]   len_minutes;
		bit [HMS_W-1:0]   len_seconds;
		bit               counting;
		bit [TOTAL_W-1:0] elapsed;
		timer_reading_t   pending_readings[$];
		int unsigned      fault_count;

		// remainder taken into 0..59, negative sums wrap upward
		function bit [HMS_W-1:0] wrap_field(int v);
			int r;
			r = v % FIELD_MODULUS;
			if (r < 0) begin
				r += FIELD_MODULUS;
			end
			return r[HMS_W-1:0];
		endfunction

		function void note_request(timer_request_t rq);
			int amount;
			int length;
			int left;
			timer_reading_t rd;
			amount = int'($signed(rq.amount));
			case (rq.kind)
				REQ_SET, REQ_ADD: begin
					case (rq.sel)
						SEL_HOURS: begin
							len_hours = wrap_field((rq.kind == REQ_ADD ? int'(len_hours) : 0)
								+ amount);
						end
						SEL_MINUTES: begin
							len_minutes = wrap_field((rq.kind == REQ_ADD ? int'(len_minutes) : 0)
								+ amount);
						end
						SEL_SECONDS: begin
							len_seconds = wrap_field((rq.kind == REQ_ADD ? int'(len_seconds) : 0)
								+ amount);
						end
						default: ;
					endcase
				end
				REQ_START: counting = 1'b1;
				REQ_PAUSE: counting = 1'b0;
				REQ_RESET: begin
					counting = 1'b0;
					elapsed  = '0;
				end
				REQ_TICK: begin
					if (counting && elapsed != ELAPSED_MAX) begin
						elapsed = elapsed + 1'b1;
					end
				end
				default: ;
			endcase
			length = int'(len_hours) * SECS_PER_HOUR + int'(len_minutes) * SECS_PER_MIN
				+ int'(len_seconds);
			left = (int'(elapsed) < length) ? length - int'(elapsed) : 0;
			rd.total   = left[TOTAL_W-1:0];
			rd.hours   = HMS_W'(left / SECS_PER_HOUR);
			rd.minutes = HMS_W'((left % SECS_PER_HOUR) / SECS_PER_MIN);
			rd.seconds = HMS_W'(left % SECS_PER_MIN);
			rd.running = counting;
			rd.paused  = !counting && elapsed != '0;
			rd.expired = int'(elapsed) >= length;
			pending_readings.push_back(rd);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				fault_count++;
			end
		endfunction

		function void check_result(timer_reading_t got);
			timer_reading_t want;
			if (pending_readings.size() == 0) begin
				$error("result transfer with no request outstanding");
				fault_count++;
				return;
			end
			want = pending_readings.pop_front();
			compare_field("remaining_total", 32'(want.total), 32'(got.total));
			compare_field("remaining_hours", 32'(want.hours), 32'(got.hours));
			compare_field("remaining_minutes", 32'(want.minutes), 32'(got.minutes));
			compare_field("remaining_secs", 32'(want.seconds), 32'(got.seconds));
			compare_field("is_running", 32'(want.running), 32'(got.running));
			compare_field("is_paused", 32'(want.paused), 32'(got.paused));
			compare_field("is_expired", 32'(want.expired), 32'(got.expired));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	// requests left in the current burst and requests sent so far
	int burst_left = 0;
	int sent_count = 0;

	countdown_scoreboard sb = new;

	cth_req_if req_bus ();
	cth_rsp_if rsp_bus ();

	countdown_timer_hms_pause_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #10 clk = ~clk;

	// monitor: both channels sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
				sb.note_request(timer_request_t'{req_bus.req_type, req_bus.field_select,
					req_bus.value});
			end
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
				sb.check_result(timer_reading_t'{rsp_bus.remaining_total,
					rsp_bus.remaining_hours, rsp_bus.remaining_minutes,
					rsp_bus.remaining_secs, rsp_bus.is_running, rsp_bus.is_paused,
					rsp_bus.is_expired});
			end
		end
	end

	// result side: each pattern holds for a random span of cycles
	initial begin
		int mode;
		int span;
		int phase;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: rsp_bus.ready <= 1'b1;
					1: rsp_bus.ready <= 1'($urandom);
					2: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
					default: rsp_bus.ready <= ((phase % 10) >= 7);
				endcase
			end
		end
	end

	// drive one request from a falling edge and hold it until the transfer
	task automatic send_request(timer_request_t rq);
		req_bus.valid        <= 1'b1;
		req_bus.req_type     <= rq.kind;
		req_bus.field_select <= rq.sel;
		req_bus.value        <= rq.amount;
		do begin
			@(posedge clk);
		end while (req_bus.ready !== 1'b1);
		@(negedge clk);
		sent_count++;
	endtask

	// bursts of random length, separated by random gaps; some gaps are zero
	task automatic send_paced(timer_request_t rq);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		send_request(rq);
	endtask

	function automatic timer_request_t make_request(logic [REQ_W-1:0] kind,
		logic [SEL_W-1:0] sel, int amount);
		timer_request_t rq;
		rq.kind   = kind;
		rq.sel    = sel;
		rq.amount = VALUE_W'(amount);
		return rq;
	endfunction

	// one loose request: mostly ticks and length edits, with noise in unused fields
	function automatic timer_request_t random_request();
		timer_request_t rq;
		int pick;
		pick      = $urandom_range(0, 99);
		rq.sel    = SEL_W'($urandom);
		rq.amount = VALUE_W'($urandom);
		if (pick < 40) begin
			rq.kind = REQ_TICK;
		end else if (pick < 48) begin
			rq.kind = REQ_START;
		end else if (pick < 54) begin
			rq.kind = REQ_PAUSE;
		end else if (pick < 58) begin
			rq.kind = REQ_RESET;
		end else if (pick < 62) begin
			rq.kind = REQ_STATUS;
		end else if (pick < 64) begin
			rq.kind = REQ_UNUSED;
		end else begin
			rq.kind = (pick < 82) ? REQ_SET : REQ_ADD;
			rq.sel  = ($urandom_range(0, 9) == 0) ? SEL_INVALID : SEL_W'($urandom_range(0, 2));
			// full-range values now and then, otherwise short lengths that can expire
			if ($urandom_range(0, 4) != 0) begin
				if (rq.kind == REQ_ADD) begin
					rq.amount = VALUE_W'($urandom_range(0, 140) - 70);
				end else if (rq.sel == SEL_HOURS && $urandom_range(0, 9) < 7) begin
					rq.amount = '0;
				end else begin
					rq.amount = VALUE_W'($urandom_range(0, 59));
				end
			end
		end
		return rq;
	endfunction

	// program a short length, start and count it down with pauses along the way
	task automatic run_countdown();
		int ticks;
		int pick;
		send_paced(make_request(REQ_SET, SEL_HOURS, 0));
		send_paced(make_request(REQ_SET, SEL_MINUTES, $urandom_range(0, 2)));
		send_paced(make_request(REQ_SET, SEL_SECONDS, $urandom_range(0, 59)));
		send_paced(make_request(REQ_START, SEL_W'($urandom), int'($urandom)));
		ticks = $urandom_range(0, 200);
		repeat (ticks) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_paced(make_request(REQ_PAUSE, SEL_W'($urandom), int'($urandom)));
			end else if (pick < 6) begin
				send_paced(make_request(REQ_START, SEL_W'($urandom), int'($urandom)));
			end else if (pick < 8) begin
				send_paced(random_request());
			end else begin
				send_paced(make_request(REQ_TICK, SEL_W'($urandom), int'($urandom)));
			end
		end
		if ($urandom_range(0, 1) == 1) begin
			send_paced(make_request(REQ_RESET, SEL_W'($urandom), int'($urandom)));
		end
	endtask

	// watchdog, several times the slowest passing run
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		req_bus.valid        = 1'b0;
		req_bus.req_type     = REQ_STATUS;
		req_bus.field_select = SEL_HOURS;
		req_bus.value        = '0;
		rsp_bus.ready        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, field extremes, wrapping and the control corners
		send_paced(make_request(REQ_STATUS, SEL_HOURS, 0));
		send_paced(make_request(REQ_TICK, SEL_HOURS, 0));        // tick while stopped
		send_paced(make_request(REQ_PAUSE, SEL_HOURS, 0));       // pause while stopped
		send_paced(make_request(REQ_SET, SEL_HOURS, 59));
		send_paced(make_request(REQ_SET, SEL_MINUTES, -1));      // negative set wraps up
		send_paced(make_request(REQ_SET, SEL_SECONDS, 4095));
		send_paced(make_request(REQ_ADD, SEL_SECONDS, 44));
		send_paced(make_request(REQ_SET, SEL_INVALID, -4096));   // ignored selector
		send_paced(make_request(REQ_ADD, SEL_INVALID, 4095));
		send_paced(make_request(REQ_SET, SEL_HOURS, -4096));
		send_paced(make_request(REQ_ADD, SEL_HOURS, 16));        // add wraps past 59
		send_paced(make_request(REQ_ADD, SEL_MINUTES, -4096));
		send_paced(make_request(REQ_SET, SEL_MINUTES, 0));
		send_paced(make_request(REQ_SET, SEL_SECONDS, 3));
		send_paced(make_request(REQ_START, SEL_HOURS, 0));
		send_paced(make_request(REQ_START, SEL_HOURS, 0));       // start while running
		repeat (4) begin
			// runs one tick past expiry so the remaining time clamps at zero
			send_paced(make_request(REQ_TICK, SEL_MINUTES, 0));
		end
		send_paced(make_request(REQ_PAUSE, SEL_HOURS, 0));
		send_paced(make_request(REQ_START, SEL_HOURS, 0));
		send_paced(make_request(REQ_TICK, SEL_HOURS, 0));
		send_paced(make_request(REQ_RESET, SEL_HOURS, 0));
		send_paced(make_request(REQ_UNUSED, SEL_INVALID, -1));

		// random: mostly countdown sequences, the rest loose requests
		sent_count = 0;
		while (sent_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 3) begin
				run_countdown();
			end else begin
				send_paced(random_request());
			end
		end
		req_bus.valid <= 1'b0;

		// drain every outstanding reading, then keep watching for stray results
		while (sb.pending_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fault_count == 0 && sb.pending_readings.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
